FILE: hw/rtl/stse_pkg.sv
// Shared types, constants and the digit segment table for the speed/time
// segment encoder. No dependencies.
`default_nettype none

package stse_pkg;

  // Input word: one display refresh request
  typedef struct packed {
    logic [13:0] speed_value;
    logic [12:0] time_seconds;
    logic        speed_digits_blank;
    logic        time_digits_blank;
    logic        unit_icons_blank;
    logic        lock_icons_blank;
    logic        speed_in_rcf;
    logic        lid_locked;
  } stse_in_t;

  // Output word: panel bytes for addresses 0, 2, 4, 6, 8 and 10
  typedef struct packed {
    logic [7:0] segment_byte_0;
    logic [7:0] segment_byte_2;
    logic [7:0] segment_byte_4;
    logic [7:0] segment_byte_6;
    logic [7:0] segment_byte_8;
    logic [7:0] segment_byte_10;
    logic       time_in_minutes;
  } stse_out_t;

  // Decimal digits and blanking status handed from the splitter to the formatter
  typedef struct packed {
    logic [3:0] spd_hund;
    logic [3:0] spd_tens;
    logic [3:0] spd_units;
    logic       spd_ge100;
    logic       spd_ge10;
    logic [3:0] time_tens;
    logic [3:0] time_units;
    logic       minutes;
  } stse_digits_t;

  localparam logic [12:0] TIME_MAX_SECONDS = 13'd5999;
  localparam logic [12:0] MINUTE_SECONDS   = 13'd60;

  // Reciprocals: floor(x * RECIP >> SHIFT) equals the quotient over the used range
  localparam logic [15:0] RECIP_10_SPD   = 16'd52429;  // >> 19, speed / 10
  localparam logic [12:0] RECIP_100_SPD  = 13'd5243;   // >> 19, speed / 100
  localparam logic [14:0] RECIP_1000_SPD = 15'd16778;  // >> 24, speed / 1000
  localparam logic [14:0] RECIP_60_TIME  = 15'd17477;  // >> 20, seconds / 60
  localparam logic [12:0] RECIP_600_TIME = 13'd6991;   // >> 22, seconds / 600
  localparam logic [6:0]  RECIP_10_SEC   = 7'd103;     // >> 10, seconds below 60 / 10

  function automatic logic [7:0] digit_seg(input logic [3:0] d);
    logic [7:0] code;
    case (d)
      4'd0:    code = 8'h5F;
      4'd1:    code = 8'h06;
      4'd2:    code = 8'h3D;
      4'd3:    code = 8'h2F;
      4'd4:    code = 8'h66;
      4'd5:    code = 8'h6B;
      4'd6:    code = 8'h7B;
      4'd7:    code = 8'h0E;
      4'd8:    code = 8'h7F;
      4'd9:    code = 8'h6F;
      default: code = 8'h00;
    endcase
    return code;
  endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/stse_digits.sv
// Splits speed and time into decimal digits with reciprocal multiplies.
// Depends on stse_pkg.
`default_nettype none

module stse_digits
  import stse_pkg::*;
(
  input  wire logic [13:0] speed,
  input  wire logic [12:0] tsec,
  output stse_digits_t     digits
);

  logic [29:0] sp_p10;
  logic [26:0] sp_p100;
  logic [28:0] sp_p1000;
  logic [10:0] q10;
  logic [7:0]  q100;
  logic [4:0]  q1000;
  logic [13:0] q10_x10;
  logic [10:0] q100_x10;
  logic [7:0]  q1000_x10;
  logic [13:0] units_diff;
  logic [10:0] tens_diff;
  logic [7:0]  hund_diff;

  logic [12:0] tsat;
  logic        minutes;
  logic [27:0] t_p60;
  logic [25:0] t_p600;
  logic [6:0]  mins;
  logic [3:0]  min_tens;
  logic [6:0]  min_tens_x10;
  logic [6:0]  min_units_diff;
  logic [5:0]  secs;
  logic [12:0] s_p10;
  logic [2:0]  sec_tens;
  logic [5:0]  sec_tens_x10;
  logic [5:0]  sec_units_diff;

  // Speed: each digit comes straight from the input, no chained divides
  assign sp_p10   = speed * RECIP_10_SPD;
  assign sp_p100  = speed * RECIP_100_SPD;
  assign sp_p1000 = speed * RECIP_1000_SPD;
  assign q10      = sp_p10[29:19];
  assign q100     = sp_p100[26:19];
  assign q1000    = sp_p1000[28:24];

  assign q10_x10    = {q10, 3'b000} + {2'b00, q10, 1'b0};
  assign q100_x10   = {q100, 3'b000} + {2'b00, q100, 1'b0};
  assign q1000_x10  = {q1000, 3'b000} + {2'b00, q1000, 1'b0};
  assign units_diff = speed - q10_x10;
  assign tens_diff  = q10 - q100_x10;
  assign hund_diff  = q100 - q1000_x10;

  // Time: saturate, then minutes or seconds
  assign tsat    = (tsec > TIME_MAX_SECONDS) ? TIME_MAX_SECONDS : tsec;
  assign minutes = (tsat >= MINUTE_SECONDS);

  assign t_p60          = tsat * RECIP_60_TIME;
  assign t_p600         = tsat * RECIP_600_TIME;
  assign mins           = t_p60[26:20];
  assign min_tens       = t_p600[25:22];
  assign min_tens_x10   = {min_tens, 3'b000} + {2'b00, min_tens, 1'b0};
  assign min_units_diff = mins - min_tens_x10;

  assign secs           = tsat[5:0];
  assign s_p10          = secs * RECIP_10_SEC;
  assign sec_tens       = s_p10[12:10];
  assign sec_tens_x10   = {sec_tens, 3'b000} + {2'b00, sec_tens, 1'b0};
  assign sec_units_diff = secs - sec_tens_x10;

  always_comb begin
    digits.spd_units  = units_diff[3:0];
    digits.spd_tens   = tens_diff[3:0];
    digits.spd_hund   = hund_diff[3:0];
    digits.spd_ge100  = (speed > 14'd99);
    digits.spd_ge10   = (speed > 14'd9);
    digits.minutes    = minutes;
    if (minutes) begin
      digits.time_tens  = min_tens;
      digits.time_units = min_units_diff[3:0];
    end else begin
      digits.time_tens  = {1'b0, sec_tens};
      digits.time_units = sec_units_diff[3:0];
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/stse_format.sv
// Maps digits to segment codes and places icons into the panel bytes.
// Depends on stse_pkg.
`default_nettype none

module stse_format
  import stse_pkg::*;
(
  input  wire stse_in_t     in_word,
  input  wire stse_digits_t digits,
  output stse_out_t         out_word
);

  logic [7:0] hund_seg;
  logic [7:0] tens_seg;
  logic [7:0] units_seg;
  logic [7:0] ttens_seg;
  logic [7:0] tunits_seg;
  logic       icons_on;
  logic       lock_on;

  assign icons_on = !in_word.unit_icons_blank;
  assign lock_on  = !in_word.lock_icons_blank;

  always_comb begin
    hund_seg   = 8'h00;
    tens_seg   = 8'h00;
    units_seg  = 8'h00;
    ttens_seg  = 8'h00;
    tunits_seg = 8'h00;
    // Blank leading speed zeros; the speed units digit shows unless speed digits are blanked
    if (!in_word.speed_digits_blank) begin
      if (digits.spd_ge100) hund_seg = digit_seg(digits.spd_hund);
      if (digits.spd_ge10)  tens_seg = digit_seg(digits.spd_tens);
      units_seg = digit_seg(digits.spd_units);
    end
    if (!in_word.time_digits_blank) begin
      ttens_seg  = digit_seg(digits.time_tens);
      tunits_seg = digit_seg(digits.time_units);
    end
  end

  always_comb begin
    out_word.segment_byte_0  = {icons_on & in_word.speed_in_rcf, hund_seg[6:0]};
    out_word.segment_byte_2  = {lock_on & in_word.lid_locked, tens_seg[6:0]};
    out_word.segment_byte_4  = {lock_on & !in_word.lid_locked, units_seg[6:0]};
    out_word.segment_byte_6  = {icons_on & !in_word.speed_in_rcf, ttens_seg[6:0]};
    // Address 8: lid base, upper time-units segments, min icon, sec icon
    out_word.segment_byte_8  = {lock_on, tunits_seg[6:4], icons_on & digits.minutes,
                                2'b00, icons_on & !digits.minutes};
    out_word.segment_byte_10 = {tunits_seg[3:0], 4'b0000};
    out_word.time_in_minutes = digits.minutes;
  end

endmodule

`default_nettype wire

FILE: hw/rtl/speed_time_segment_encoder.sv
// Top level of the speed/time segment encoder: input register, digit split,
// formatting and output register. Depends on stse_pkg, stse_digits, stse_format.
`default_nettype none

// Takes one word per clock while out_ready is high and gives one result word for
// it: the word is captured in an input register, split into digits and formatted
// in one combinational pass, and held in an output register until taken. in_ready
// drops only while both registers are full and out_ready is low.
module speed_time_segment_encoder
  import stse_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     in_valid,
  output logic          in_ready,
  input  wire stse_in_t in_word,
  output logic          out_valid,
  input  wire logic     out_ready,
  output stse_out_t     out_word
);

  logic         stage_valid;
  stse_in_t     stage_word;
  logic         out_advance;
  stse_digits_t digits;
  stse_out_t    result;

  assign out_advance = !out_valid || out_ready;
  assign in_ready    = !stage_valid || out_advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      if (in_ready) stage_valid <= in_valid;
      if (out_advance) out_valid <= stage_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) stage_word <= in_word;
    if (out_advance && stage_valid) out_word <= result;
  end

  stse_digits u_digits (
    .speed  (stage_word.speed_value),
    .tsec   (stage_word.time_seconds),
    .digits (digits)
  );

  stse_format u_format (
    .in_word  (stage_word),
    .digits   (digits),
    .out_word (result)
  );

endmodule

`default_nettype wire

FILE: hw/rtl/stse_checker.sv
// Port-level checks for the speed/time segment encoder and the bind that
// attaches them. Depends on stse_pkg and speed_time_segment_encoder.
`default_nettype none

module stse_checker
  import stse_pkg::*;
(
  input wire logic      clk,
  input wire logic      rst,
  input wire logic      in_ready,
  input wire logic      out_valid,
  input wire logic      out_ready,
  input wire stse_out_t out_word
);

  // A held result word does not change
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_word))
    else $error("stalled result word changed");

  // Reset empties the output register
  assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid after reset");

  // With no result waiting the block always takes a new word
  assert property (@(posedge clk) disable iff (rst) !out_valid |-> in_ready)
    else $error("input stalled while output empty");

  // Min and sec icons are exclusive; unused bits stay clear
  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(out_word.segment_byte_8[3] && out_word.segment_byte_8[0])
                  && out_word.segment_byte_8[2:1] == 2'b00
                  && out_word.segment_byte_10[3:0] == 4'b0000)
    else $error("bad time icon or unit nibble bits");

  // Min icon only when the time is in minutes
  assert property (@(posedge clk) disable iff (rst)
    out_valid && out_word.segment_byte_8[3] |-> out_word.time_in_minutes)
    else $error("min icon without minutes");

endmodule

bind speed_time_segment_encoder stse_checker u_stse_checker (
  .clk       (clk),
  .rst       (rst),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_word  (out_word)
);

`default_nettype wire

FILE: sim/tb_speed_time_segment_encoder.sv
// Testbench for speed_time_segment_encoder: directed and random display words
// with random idling on both handshakes, checked against a local predictor.
// Depends on stse_pkg and the encoder RTL.
`timescale 1ns / 100ps

module tb_speed_time_segment_encoder;
  import stse_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int RANDOM_WORDS   = 1750;
  // segment codes for digits 9 down to 0, digit d at bits [8*d +: 8]
  localparam logic [79:0] SEG_CODES =
    {8'h6F, 8'h7F, 8'h0E, 8'h7B, 8'h6B, 8'h66, 8'h2F, 8'h3D, 8'h06, 8'h5F};
  localparam int unsigned TIME_CAP = 5999;

  // flag bit positions used by make_word
  localparam int F_SBLANK = 5;
  localparam int F_TBLANK = 4;
  localparam int F_IBLANK = 3;
  localparam int F_LBLANK = 2;
  localparam int F_RCF    = 1;
  localparam int F_LOCKED = 0;

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      in_valid = 1'b0;
  logic      in_ready;
  stse_in_t  in_word = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  stse_out_t out_word;

  stse_out_t pending_segments[$];
  int        error_count = 0;
  int        sent_count = 0;
  int        minute_words = 0;
  int        over_range_words = 0;
  bit        steady_flow = 1'b0;

  speed_time_segment_encoder uut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_word   (in_word),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_word  (out_word)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic logic [7:0] seg_of(input int unsigned d);
    return SEG_CODES[(d % 10) * 8 +: 8];
  endfunction

  function automatic stse_out_t predict_segments(input stse_in_t w);
    int unsigned spd, tsec, hi, lo;
    logic [7:0]  b0, b2, b4, b6, b8, b10, units;
    logic        minutes;
    stse_out_t   r;
    spd = w.speed_value;
    tsec = w.time_seconds;
    b0 = 8'h00; b2 = 8'h00; b4 = 8'h00; b6 = 8'h00; units = 8'h00;
    if (!w.speed_digits_blank) begin
      if (spd > 99) b0 = seg_of(spd / 100);
      if (spd > 9) b2 = seg_of(spd / 10);
      b4 = seg_of(spd);
    end
    if (tsec > TIME_CAP) tsec = TIME_CAP;
    minutes = (tsec >= 60);
    if (minutes) begin
      hi = (tsec / 60) / 10;
      lo = (tsec / 60) % 10;
    end else begin
      hi = tsec / 10;
      lo = tsec % 10;
    end
    if (!w.time_digits_blank) begin
      b6 = seg_of(hi);
      units = seg_of(lo);
    end
    b8 = units & 8'hF0;
    b10 = {units[3:0], 4'h0};
    if (!w.unit_icons_blank) begin
      if (w.speed_in_rcf) b0 = b0 | 8'h80;
      else b6 = b6 | 8'h80;
      b8 = (b8 & 8'hF5) | (minutes ? 8'h08 : 8'h01);
    end else begin
      b0 = b0 & 8'h7F;
      b6 = b6 & 8'h7F;
      b8 = b8 & 8'hF5;
    end
    if (!w.lock_icons_blank) begin
      if (w.lid_locked) b2 = b2 | 8'h80;
      else b4 = b4 | 8'h80;
      b8 = b8 | 8'h80;
    end else begin
      b2 = b2 & 8'h7F;
      b4 = b4 & 8'h7F;
      b8 = b8 & 8'h7F;
    end
    r.segment_byte_0  = b0;
    r.segment_byte_2  = b2;
    r.segment_byte_4  = b4;
    r.segment_byte_6  = b6;
    r.segment_byte_8  = b8;
    r.segment_byte_10 = b10;
    r.time_in_minutes = minutes;
    return r;
  endfunction

  function automatic stse_in_t make_word(input int unsigned spd, input int unsigned tsec,
                                         input logic [5:0] flags);
    stse_in_t w;
    w.speed_value        = spd[13:0];
    w.time_seconds       = tsec[12:0];
    w.speed_digits_blank = flags[F_SBLANK];
    w.time_digits_blank  = flags[F_TBLANK];
    w.unit_icons_blank   = flags[F_IBLANK];
    w.lock_icons_blank   = flags[F_LBLANK];
    w.speed_in_rcf       = flags[F_RCF];
    w.lid_locked         = flags[F_LOCKED];
    return w;
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("[%0t] %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
    error_count++;
  endtask

  task automatic send_word(input stse_in_t w);
    int gap;
    gap = steady_flow ? 0 : $urandom_range(0, 10);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_word <= w;
    do @(posedge clk); while (!in_ready);
    pending_segments.push_back(predict_segments(w));
    sent_count++;
    if (w.time_seconds >= 60) minute_words++;
    if (w.speed_value > 9999 || w.time_seconds > TIME_CAP) over_range_words++;
  endtask

  task automatic compare_word(input stse_out_t got);
    stse_out_t want;
    if (pending_segments.size() == 0) begin
      report_mismatch("word with nothing expected", got.segment_byte_0, 0);
      return;
    end
    want = pending_segments.pop_front();
    if (got.segment_byte_0 !== want.segment_byte_0)
      report_mismatch("segment_byte_0", got.segment_byte_0, want.segment_byte_0);
    if (got.segment_byte_2 !== want.segment_byte_2)
      report_mismatch("segment_byte_2", got.segment_byte_2, want.segment_byte_2);
    if (got.segment_byte_4 !== want.segment_byte_4)
      report_mismatch("segment_byte_4", got.segment_byte_4, want.segment_byte_4);
    if (got.segment_byte_6 !== want.segment_byte_6)
      report_mismatch("segment_byte_6", got.segment_byte_6, want.segment_byte_6);
    if (got.segment_byte_8 !== want.segment_byte_8)
      report_mismatch("segment_byte_8", got.segment_byte_8, want.segment_byte_8);
    if (got.segment_byte_10 !== want.segment_byte_10)
      report_mismatch("segment_byte_10", got.segment_byte_10, want.segment_byte_10);
    if (got.time_in_minutes !== want.time_in_minutes)
      report_mismatch("time_in_minutes", got.time_in_minutes, want.time_in_minutes);
  endtask

  // Output side: stall a random number of cycles per word, then take it
  initial begin : result_taker
    int stall;
    do @(posedge clk); while (rst);
    forever begin
      stall = steady_flow ? 0 : $urandom_range(0, 10);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      compare_word(out_word);
    end
  end

  initial begin : watchdog
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles = 0;
      else idle_cycles++;
    end
    $display("watchdog: no handshake for %0d cycles", WATCHDOG_LIMIT);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  function automatic int unsigned rand_speed();
    case ($urandom_range(0, 9))
      0: return $urandom_range(0, 9);
      1: return $urandom_range(10, 99);
      2: return $urandom_range(100, 999);
      3: return $urandom_range(1000, 9999);
      4: return $urandom_range(10000, 16383);
      5: return $urandom_range(95, 105);
      default: return $urandom_range(0, 9999);
    endcase
  endfunction

  function automatic int unsigned rand_time();
    case ($urandom_range(0, 9))
      0: return $urandom_range(0, 59);
      1: return $urandom_range(55, 65);
      2: return $urandom_range(5990, 6010);
      3: return $urandom_range(6000, 8191);
      4: return $urandom_range(590, 610);
      default: return $urandom_range(0, 5999);
    endcase
  endfunction

  // Digit boundaries of the speed field, leading blanking, wrap past 9999
  task automatic test_speed_edges();
    send_word(make_word(0, 0, 6'b000000));
    send_word(make_word(9, 0, 6'b000001));
    send_word(make_word(10, 0, 6'b000010));
    send_word(make_word(99, 0, 6'b000011));
    send_word(make_word(100, 0, 6'b000000));
    send_word(make_word(999, 0, 6'b000000));
    send_word(make_word(1000, 0, 6'b000000));
    send_word(make_word(9999, 0, 6'b000000));
    send_word(make_word(16383, 0, 6'b000000));
  endtask

  // Seconds/minutes switch and saturation of the time field
  task automatic test_time_edges();
    send_word(make_word(5, 59, 6'b000000));
    send_word(make_word(5, 60, 6'b000000));
    send_word(make_word(5, 599, 6'b000000));
    send_word(make_word(5, 600, 6'b000000));
    send_word(make_word(5, 5999, 6'b000000));
    send_word(make_word(5, 6000, 6'b000000));
    send_word(make_word(5, 8191, 6'b000000));
  endtask

  // Each blank flag on its own, and everything blanked
  task automatic test_blanking();
    send_word(make_word(888, 4321, 6'b100000));
    send_word(make_word(888, 4321, 6'b010000));
    send_word(make_word(888, 45, 6'b001000));
    send_word(make_word(888, 4321, 6'b001010));
    send_word(make_word(888, 4321, 6'b000101));
    send_word(make_word(888, 4321, 6'b000111));
    send_word(make_word(16383, 8191, 6'b111111));
  endtask

  task automatic test_random_words(input int count);
    stse_in_t w;
    for (int i = 0; i < count; i++) begin
      // run a full-rate stretch now and then
      if (i % 250 == 100) steady_flow = 1'b1;
      if (i % 250 == 160) steady_flow = 1'b0;
      w = make_word(rand_speed(), rand_time(), 6'($urandom_range(0, 63)));
      send_word(w);
    end
    steady_flow = 1'b0;
  endtask

  // Hold the sender until the pipeline is empty, then restart from cold
  task automatic test_drain_pause();
    test_random_words(30);
    in_valid <= 1'b0;
    while (pending_segments.size() != 0) @(posedge clk);
    test_random_words(30);
  endtask

  initial begin : main
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_speed_edges();
    test_time_edges();
    test_blanking();
    test_drain_pause();
    test_random_words(RANDOM_WORDS);

    in_valid <= 1'b0;
    while (pending_segments.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (pending_segments.size() != 0)
      report_mismatch("words never delivered", 0, pending_segments.size());

    $display("%0d words sent, %0d in minute mode, %0d with out-of-range fields",
             sent_count, minute_words, over_range_words);
    $display("random idling on both handshakes, full-rate stretches and one drain pause");
    if (error_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("%0d mismatches", error_count);
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

FILE: filelist.f
hw/rtl/stse_pkg.sv
hw/rtl/stse_digits.sv
hw/rtl/stse_format.sv
hw/rtl/speed_time_segment_encoder.sv
hw/rtl/stse_checker.sv
sim/tb_speed_time_segment_encoder.sv
